// ----- hdl/ptoc_pkg.sv -----
package ptoc_pkg;

    localparam int unsigned MAX_TILES_DEFAULT = 64;

    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned TS_W       = 9;
    localparam int unsigned THR_W      = 8;
    localparam int unsigned DIM_W      = 13;
    localparam int unsigned CH_W       = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned POS_W      = 12;
    localparam int unsigned IN_TILE_W  = 8;
    localparam int unsigned COL_W      = 6;
    localparam int unsigned BOX_W_W    = 7;
    localparam int unsigned BOX_H_W    = 13;
    localparam int unsigned ACC_W      = 14;

    localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_THRESH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd4;

    localparam logic [TS_W-1:0]  TILE_SIZE_RESET     = 9'd16;
    localparam logic [THR_W-1:0] ALPHA_THRESH_RESET  = 8'd8;
    localparam logic [DIM_W-1:0] IMAGE_WIDTH_RESET   = 13'd64;
    localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RESET  = 13'd64;
    localparam logic [CH_W-1:0]  CHANNEL_COUNT_RESET = 3'd4;

    localparam logic [TS_W-1:0]  TILE_SIZE_MAX  = 9'd256;
    localparam logic [DIM_W-1:0] IMAGE_DIM_MAX  = 13'd4096;
    localparam logic [CH_W-1:0]  CHANNEL_MAX    = 3'd4;

    localparam logic [COL_W-1:0] MIN_COL_RESET = '1;
    localparam logic [POS_W-1:0] MIN_ROW_RESET = '1;

    typedef struct packed {
        logic [POS_W-1:0] band_index;
        logic             img_end;
    } band_info_t;

endpackage

// ----- hdl/ptoc_front.sv -----
module ptoc_front #(
    parameter int unsigned MAX_TILES_PER_ROW = ptoc_pkg::MAX_TILES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [ptoc_pkg::CHAN_W-1:0]       chan0,
    input  logic [ptoc_pkg::CHAN_W-1:0]       chan1,
    input  logic [ptoc_pkg::CHAN_W-1:0]       chan2,
    input  logic [ptoc_pkg::CHAN_W-1:0]       chan3,
    input  logic [ptoc_pkg::TS_W-1:0]         ts_eff,
    input  logic [ptoc_pkg::THR_W-1:0]        alpha_thresh,
    input  logic [ptoc_pkg::DIM_W-1:0]        width_eff,
    input  logic [ptoc_pkg::DIM_W-1:0]        height_eff,
    input  logic [ptoc_pkg::CH_W-1:0]         ch_eff,
    output logic                              push,
    output logic [MAX_TILES_PER_ROW-1:0]      push_flags,
    output ptoc_pkg::band_info_t              push_info
);

    localparam int unsigned IDX_W = (MAX_TILES_PER_ROW > 1) ? $clog2(MAX_TILES_PER_ROW) : 1;
    localparam int unsigned TCC_W = $clog2(MAX_TILES_PER_ROW + 1);
    localparam logic [TCC_W-1:0] TCC_MAX = TCC_W'(MAX_TILES_PER_ROW);

    logic [ptoc_pkg::POS_W-1:0]     pcol_reg, pcol_next;
    logic [ptoc_pkg::POS_W-1:0]     prow_reg, prow_next;
    logic [ptoc_pkg::IN_TILE_W-1:0] cit_reg, cit_next;
    logic [ptoc_pkg::IN_TILE_W-1:0] rit_reg, rit_next;
    logic [TCC_W-1:0]               tcc_reg, tcc_next;
    logic [ptoc_pkg::POS_W-1:0]     band_reg, band_next;
    logic [MAX_TILES_PER_ROW-1:0]   flags_reg, flags_next;

    logic                           accept;
    logic                           nonempty;
    logic                           set_flag;
    logic [MAX_TILES_PER_ROW-1:0]   flags_set;
    logic                           tile_wrap;
    logic                           row_end;
    logic                           img_end;
    logic                           band_end;

    assign accept = in_valid && !in_stall;

    always_comb
    begin
        if (ch_eff == ptoc_pkg::CHANNEL_MAX && chan3 <= alpha_thresh)
        begin
            nonempty = 1'b0;
        end
        else
        begin
            nonempty = (chan0 != '0)
                    || (ch_eff >= 3'd2 && chan1 != '0)
                    || (ch_eff >= 3'd3 && chan2 != '0)
                    || (ch_eff >= 3'd4 && chan3 != '0);
        end
    end

    assign set_flag  = nonempty && (tcc_reg < TCC_MAX);
    assign flags_set = flags_reg
                     | ({{(MAX_TILES_PER_ROW-1){1'b0}}, set_flag} << tcc_reg[IDX_W-1:0]);

    assign tile_wrap = ({1'b0, cit_reg} + 9'd1) >= ts_eff;
    assign row_end   = ({1'b0, pcol_reg} + 13'd1) >= width_eff;
    assign img_end   = ({1'b0, prow_reg} + 13'd1) >= height_eff;
    assign band_end  = row_end && (img_end || (({1'b0, rit_reg} + 9'd1) >= ts_eff));

    assign push                 = accept && band_end;
    assign push_flags           = flags_set;
    assign push_info.band_index = band_reg;
    assign push_info.img_end    = img_end;

    always_comb
    begin
        pcol_next  = pcol_reg;
        prow_next  = prow_reg;
        cit_next   = cit_reg;
        rit_next   = rit_reg;
        tcc_next   = tcc_reg;
        band_next  = band_reg;
        flags_next = flags_reg;
        if (accept)
        begin
            if (!row_end)
            begin
                pcol_next  = pcol_reg + 12'd1;
                flags_next = flags_set;
                if (tile_wrap)
                begin
                    cit_next = '0;
                    if (tcc_reg < TCC_MAX)
                    begin
                        tcc_next = tcc_reg + TCC_W'(1);
                    end
                end
                else
                begin
                    cit_next = cit_reg + 8'd1;
                end
            end
            else
            begin
                pcol_next = '0;
                cit_next  = '0;
                tcc_next  = '0;
                if (!img_end)
                begin
                    prow_next = prow_reg + 12'd1;
                end
                if (!band_end)
                begin
                    rit_next   = rit_reg + 8'd1;
                    flags_next = flags_set;
                end
                else
                begin
                    rit_next   = '0;
                    flags_next = '0;
                    if (img_end)
                    begin
                        prow_next = '0;
                        band_next = '0;
                    end
                    else
                    begin
                        band_next = band_reg + 12'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcol_reg  <= '0;
            prow_reg  <= '0;
            cit_reg   <= '0;
            rit_reg   <= '0;
            tcc_reg   <= '0;
            band_reg  <= '0;
            flags_reg <= '0;
        end
        else
        begin
            pcol_reg  <= pcol_next;
            prow_reg  <= prow_next;
            cit_reg   <= cit_next;
            rit_reg   <= rit_next;
            tcc_reg   <= tcc_next;
            band_reg  <= band_next;
            flags_reg <= flags_next;
        end
    end

endmodule

// ----- hdl/ptoc_queue.sv -----
module ptoc_queue #(
    parameter int unsigned FLAG_W = ptoc_pkg::MAX_TILES_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [FLAG_W-1:0]    push_flags,
    input  ptoc_pkg::band_info_t push_info,
    output logic                 full,
    output logic                 head_valid,
    output logic [FLAG_W-1:0]    head_flags,
    output ptoc_pkg::band_info_t head_info,
    input  logic                 pop
);

    logic [FLAG_W-1:0]    flags_reg [2];
    ptoc_pkg::band_info_t info_reg [2];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_flags = flags_reg[rd_ptr_reg];
    assign head_info  = info_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            flags_reg[wr_ptr_reg] <= push_flags;
            info_reg[wr_ptr_reg]  <= push_info;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hdl/ptoc_back.sv -----
module ptoc_back #(
    parameter int unsigned MAX_TILES_PER_ROW = ptoc_pkg::MAX_TILES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [ptoc_pkg::TS_W-1:0]         ts_eff,
    input  logic [ptoc_pkg::DIM_W-1:0]        width_eff,
    input  logic                              head_valid,
    input  logic [MAX_TILES_PER_ROW-1:0]      head_flags,
    input  ptoc_pkg::band_info_t              head_info,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ptoc_pkg::COL_W-1:0]        tile_col,
    output logic [ptoc_pkg::POS_W-1:0]        tile_row,
    output logic                              occupied,
    output logic                              band_last,
    output logic                              image_done,
    output logic [ptoc_pkg::COL_W-1:0]        box_x,
    output logic [ptoc_pkg::POS_W-1:0]        box_y,
    output logic [ptoc_pkg::BOX_W_W-1:0]      box_width,
    output logic [ptoc_pkg::BOX_H_W-1:0]      box_height,
    output logic                              box_empty
);

    localparam int unsigned IDX_W = (MAX_TILES_PER_ROW > 1) ? $clog2(MAX_TILES_PER_ROW) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_TILES_PER_ROW - 1);

    logic [IDX_W-1:0]                 idx_reg, idx_next;
    logic [ptoc_pkg::ACC_W-1:0]       acc_reg, acc_next;
    logic [ptoc_pkg::COL_W-1:0]       min_col_reg, min_col_next;
    logic [ptoc_pkg::COL_W-1:0]       max_col_reg, max_col_next;
    logic [ptoc_pkg::POS_W-1:0]       min_row_reg, min_row_next;
    logic [ptoc_pkg::POS_W-1:0]       max_row_reg, max_row_next;
    logic                             any_reg, any_next;
    logic                             ov_reg, ov_next;

    logic [ptoc_pkg::COL_W-1:0]       col_reg, col_next;
    logic [ptoc_pkg::POS_W-1:0]       row_reg, row_next;
    logic                             occ_reg, occ_next;
    logic                             last_reg, last_next;
    logic                             done_reg, done_next;
    logic [ptoc_pkg::COL_W-1:0]       bx_reg, bx_next;
    logic [ptoc_pkg::POS_W-1:0]       by_reg, by_next;
    logic [ptoc_pkg::BOX_W_W-1:0]     bw_reg, bw_next;
    logic [ptoc_pkg::BOX_H_W-1:0]     bh_reg, bh_next;
    logic                             be_reg, be_next;

    logic                             step;
    logic [ptoc_pkg::ACC_W-1:0]       tile_end;
    logic                             last;
    logic                             done;
    logic                             occ;
    logic [ptoc_pkg::COL_W-1:0]       col;
    logic [ptoc_pkg::POS_W-1:0]       row;
    logic [ptoc_pkg::COL_W-1:0]       upd_min_col, upd_max_col;
    logic [ptoc_pkg::POS_W-1:0]       upd_min_row, upd_max_row;
    logic                             upd_any;

    assign step     = head_valid && (!ov_reg || !out_stall);
    assign tile_end = acc_reg + ptoc_pkg::ACC_W'(ts_eff);
    assign last     = (tile_end >= ptoc_pkg::ACC_W'(width_eff)) || (idx_reg == IDX_LAST);
    assign done     = last && head_info.img_end;
    assign occ      = head_flags[idx_reg];
    assign col      = ptoc_pkg::COL_W'(idx_reg);
    assign row      = head_info.band_index;
    assign pop      = step && last;

    always_comb
    begin
        upd_min_col = min_col_reg;
        upd_max_col = max_col_reg;
        upd_min_row = min_row_reg;
        upd_max_row = max_row_reg;
        upd_any     = any_reg;
        if (occ)
        begin
            upd_min_col = (col < min_col_reg) ? col : min_col_reg;
            upd_max_col = (col > max_col_reg) ? col : max_col_reg;
            upd_min_row = (row < min_row_reg) ? row : min_row_reg;
            upd_max_row = (row > max_row_reg) ? row : max_row_reg;
            upd_any     = 1'b1;
        end
    end

    always_comb
    begin
        idx_next     = idx_reg;
        acc_next     = acc_reg;
        min_col_next = min_col_reg;
        max_col_next = max_col_reg;
        min_row_next = min_row_reg;
        max_row_next = max_row_reg;
        any_next     = any_reg;
        ov_next      = ov_reg && out_stall;
        col_next     = col_reg;
        row_next     = row_reg;
        occ_next     = occ_reg;
        last_next    = last_reg;
        done_next    = done_reg;
        bx_next      = bx_reg;
        by_next      = by_reg;
        bw_next      = bw_reg;
        bh_next      = bh_reg;
        be_next      = be_reg;
        if (step)
        begin
            ov_next   = 1'b1;
            col_next  = col;
            row_next  = row;
            occ_next  = occ;
            last_next = last;
            done_next = done;
            bx_next   = '0;
            by_next   = '0;
            bw_next   = '0;
            bh_next   = '0;
            be_next   = 1'b0;
            if (last)
            begin
                idx_next = '0;
                acc_next = '0;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
                acc_next = tile_end;
            end
            if (done)
            begin
                if (upd_any)
                begin
                    bx_next = upd_min_col;
                    by_next = upd_min_row;
                    bw_next = {1'b0, upd_max_col} - {1'b0, upd_min_col} + 7'd1;
                    bh_next = {1'b0, upd_max_row} - {1'b0, upd_min_row} + 13'd1;
                end
                else
                begin
                    be_next = 1'b1;
                end
                min_col_next = ptoc_pkg::MIN_COL_RESET;
                max_col_next = '0;
                min_row_next = ptoc_pkg::MIN_ROW_RESET;
                max_row_next = '0;
                any_next     = 1'b0;
            end
            else
            begin
                min_col_next = upd_min_col;
                max_col_next = upd_max_col;
                min_row_next = upd_min_row;
                max_row_next = upd_max_row;
                any_next     = upd_any;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            acc_reg     <= '0;
            min_col_reg <= ptoc_pkg::MIN_COL_RESET;
            max_col_reg <= '0;
            min_row_reg <= ptoc_pkg::MIN_ROW_RESET;
            max_row_reg <= '0;
            any_reg     <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            idx_reg     <= idx_next;
            acc_reg     <= acc_next;
            min_col_reg <= min_col_next;
            max_col_reg <= max_col_next;
            min_row_reg <= min_row_next;
            max_row_reg <= max_row_next;
            any_reg     <= any_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg  <= col_next;
        row_reg  <= row_next;
        occ_reg  <= occ_next;
        last_reg <= last_next;
        done_reg <= done_next;
        bx_reg   <= bx_next;
        by_reg   <= by_next;
        bw_reg   <= bw_next;
        bh_reg   <= bh_next;
        be_reg   <= be_next;
    end

    assign out_valid  = ov_reg;
    assign tile_col   = col_reg;
    assign tile_row   = row_reg;
    assign occupied   = occ_reg;
    assign band_last  = last_reg;
    assign image_done = done_reg;
    assign box_x      = bx_reg;
    assign box_y      = by_reg;
    assign box_width  = bw_reg;
    assign box_height = bh_reg;
    assign box_empty  = be_reg;

endmodule

// ----- hdl/pixel_to_tile_occupancy_unit.sv -----
// Channel   Direction  Handshake            Payload
// pixel     in         in_valid / in_stall  chan0, chan1, chan2, chan3
// tile      out        out_valid/ out_stall tile_col .. box_empty
// config    in         cfg_we               cfg_index, cfg_data
//
// One pixel word is taken per cycle unless in_stall is set; a band's tile words
// leave one per cycle unless out_stall is set, as the front end takes the next band.
// The front end stalls only when both band slots of the queue are full.
// Reset clears position, band queue and bounding box at once; no clearing pass.
// A closed band goes into a queue slot; the back end then registers its tile words.
module pixel_to_tile_occupancy_unit #(
    parameter int unsigned MAX_TILES_PER_ROW = ptoc_pkg::MAX_TILES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ptoc_pkg::CHAN_W-1:0]       chan0,
    input  logic [ptoc_pkg::CHAN_W-1:0]       chan1,
    input  logic [ptoc_pkg::CHAN_W-1:0]       chan2,
    input  logic [ptoc_pkg::CHAN_W-1:0]       chan3,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ptoc_pkg::COL_W-1:0]        tile_col,
    output logic [ptoc_pkg::POS_W-1:0]        tile_row,
    output logic                              occupied,
    output logic                              band_last,
    output logic                              image_done,
    output logic [ptoc_pkg::COL_W-1:0]        box_x,
    output logic [ptoc_pkg::POS_W-1:0]        box_y,
    output logic [ptoc_pkg::BOX_W_W-1:0]      box_width,
    output logic [ptoc_pkg::BOX_H_W-1:0]      box_height,
    output logic                              box_empty,
    input  logic                              cfg_we,
    input  logic [ptoc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ptoc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [ptoc_pkg::TS_W-1:0]    ts_reg, ts_next;
    logic [ptoc_pkg::THR_W-1:0]   thr_reg, thr_next;
    logic [ptoc_pkg::DIM_W-1:0]   width_reg, width_next;
    logic [ptoc_pkg::DIM_W-1:0]   height_reg, height_next;
    logic [ptoc_pkg::CH_W-1:0]    ch_reg, ch_next;

    logic [ptoc_pkg::TS_W-1:0]    ts_eff;
    logic [ptoc_pkg::DIM_W-1:0]   width_eff;
    logic [ptoc_pkg::DIM_W-1:0]   height_eff;
    logic [ptoc_pkg::CH_W-1:0]    ch_eff;

    logic                         push;
    logic [MAX_TILES_PER_ROW-1:0] push_flags;
    ptoc_pkg::band_info_t         push_info;
    logic                         full;
    logic                         head_valid;
    logic [MAX_TILES_PER_ROW-1:0] head_flags;
    ptoc_pkg::band_info_t         head_info;
    logic                         pop;

    always_comb
    begin
        ts_next     = ts_reg;
        thr_next    = thr_reg;
        width_next  = width_reg;
        height_next = height_reg;
        ch_next     = ch_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ptoc_pkg::REG_TILE_SIZE:     ts_next     = cfg_data[ptoc_pkg::TS_W-1:0];
                ptoc_pkg::REG_ALPHA_THRESH:  thr_next    = cfg_data[ptoc_pkg::THR_W-1:0];
                ptoc_pkg::REG_IMAGE_WIDTH:   width_next  = cfg_data;
                ptoc_pkg::REG_IMAGE_HEIGHT:  height_next = cfg_data;
                ptoc_pkg::REG_CHANNEL_COUNT: ch_next     = cfg_data[ptoc_pkg::CH_W-1:0];
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg     <= ptoc_pkg::TILE_SIZE_RESET;
            thr_reg    <= ptoc_pkg::ALPHA_THRESH_RESET;
            width_reg  <= ptoc_pkg::IMAGE_WIDTH_RESET;
            height_reg <= ptoc_pkg::IMAGE_HEIGHT_RESET;
            ch_reg     <= ptoc_pkg::CHANNEL_COUNT_RESET;
        end
        else
        begin
            ts_reg     <= ts_next;
            thr_reg    <= thr_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            ch_reg     <= ch_next;
        end
    end

    // Out-of-range register values are clamped into their legal ranges.
    assign ts_eff     = (ts_reg == '0) ? 9'd1
                      : ((ts_reg > ptoc_pkg::TILE_SIZE_MAX) ? ptoc_pkg::TILE_SIZE_MAX : ts_reg);
    assign width_eff  = (width_reg == '0) ? 13'd1
                      : ((width_reg > ptoc_pkg::IMAGE_DIM_MAX) ? ptoc_pkg::IMAGE_DIM_MAX
                                                               : width_reg);
    assign height_eff = (height_reg == '0) ? 13'd1
                      : ((height_reg > ptoc_pkg::IMAGE_DIM_MAX) ? ptoc_pkg::IMAGE_DIM_MAX
                                                                : height_reg);
    assign ch_eff     = (ch_reg == '0) ? 3'd1
                      : ((ch_reg > ptoc_pkg::CHANNEL_MAX) ? ptoc_pkg::CHANNEL_MAX : ch_reg);

    assign in_stall = full;

    ptoc_front #(
        .MAX_TILES_PER_ROW (MAX_TILES_PER_ROW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .chan0        (chan0),
        .chan1        (chan1),
        .chan2        (chan2),
        .chan3        (chan3),
        .ts_eff       (ts_eff),
        .alpha_thresh (thr_reg),
        .width_eff    (width_eff),
        .height_eff   (height_eff),
        .ch_eff       (ch_eff),
        .push         (push),
        .push_flags   (push_flags),
        .push_info    (push_info)
    );

    ptoc_queue #(
        .FLAG_W (MAX_TILES_PER_ROW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_flags (push_flags),
        .push_info  (push_info),
        .full       (full),
        .head_valid (head_valid),
        .head_flags (head_flags),
        .head_info  (head_info),
        .pop        (pop)
    );

    ptoc_back #(
        .MAX_TILES_PER_ROW (MAX_TILES_PER_ROW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .ts_eff     (ts_eff),
        .width_eff  (width_eff),
        .head_valid (head_valid),
        .head_flags (head_flags),
        .head_info  (head_info),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .tile_col   (tile_col),
        .tile_row   (tile_row),
        .occupied   (occupied),
        .band_last  (band_last),
        .image_done (image_done),
        .box_x      (box_x),
        .box_y      (box_y),
        .box_width  (box_width),
        .box_height (box_height),
        .box_empty  (box_empty)
    );

endmodule
